[src/bolb_pkg.sv]
`timescale 1ns / 1ps
package bolb_pkg;
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_GEOM,
		ST_AREA,
		ST_SUMS,
		ST_DIV,
		ST_NEXT,
		ST_DONE,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;      // capture request
		logic rd;        // register table entry
		logic geom;      // intersection / area terms
		logic area;      // area products
		logic sums;      // num/den and decision
		logic div_start;
		logic fold;      // fold overlap into best
		logic next;      // advance box index
		logic finish;    // form result
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic is_query;
		logic empty;
		logic first_neg;
		logic last_box;
		logic need_div;
		logic div_done;
	} sts_t;
endpackage

[src/bolb_if.sv]
`timescale 1ns / 1ps
interface bolb_in_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [1:0]            command;
	logic [COORD_BITS-1:0] lo_left;
	logic [COORD_BITS-1:0] lo_top;
	logic [COORD_BITS-1:0] lo_right;
	logic [COORD_BITS-1:0] lo_bottom;
	logic [COORD_BITS-1:0] hi_left;
	logic [COORD_BITS-1:0] hi_top;
	logic [COORD_BITS-1:0] hi_right;
	logic [COORD_BITS-1:0] hi_bottom;
	logic                  negative_image;
	modport source (output valid, command, lo_left, lo_top, lo_right, lo_bottom,
		hi_left, hi_top, hi_right, hi_bottom, negative_image, input ready);
	modport sink (input valid, command, lo_left, lo_top, lo_right, lo_bottom,
		hi_left, hi_top, hi_right, hi_bottom, negative_image, output ready);
endinterface

interface bolb_out_if #(parameter int FRAC_BITS = 16);
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS:0]   loss_value;
	logic                 status;
	modport source (output valid, loss_value, status, input ready);
	modport sink (input valid, loss_value, status, output ready);
endinterface

[src/bolb_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module bolb_div #(
	parameter int NW = 40,
	parameter int DW = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW:0]   sub;

	assign trial = {rem_q[DW-1:0], q_q[NW-1]};
	assign sub   = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!sub[DW]) begin
				rem_q <= sub;
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule

[src/bolb_ctrl.sv]
`timescale 1ns / 1ps
module bolb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bolb_pkg::sts_t    sts,
	output bolb_pkg::ctl_t    ctl
);
	bolb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bolb_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			bolb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.take = 1'b1;
					state_d  = bolb_pkg::ST_READ;
				end
			end
			bolb_pkg::ST_READ: begin
				if (!sts.is_query || sts.empty || sts.first_neg) begin
					ctl.finish = 1'b1;
					state_d    = bolb_pkg::ST_OUT;
				end else begin
					ctl.rd  = 1'b1;
					state_d = bolb_pkg::ST_GEOM;
				end
			end
			bolb_pkg::ST_GEOM: begin
				ctl.geom = 1'b1;
				state_d  = bolb_pkg::ST_AREA;
			end
			bolb_pkg::ST_AREA: begin
				ctl.area = 1'b1;
				state_d  = bolb_pkg::ST_SUMS;
			end
			bolb_pkg::ST_SUMS: begin
				ctl.sums = 1'b1;
				state_d  = bolb_pkg::ST_NEXT;
			end
			bolb_pkg::ST_NEXT: begin
				if (sts.need_div) begin
					ctl.div_start = 1'b1;
					state_d       = bolb_pkg::ST_DIV;
				end else begin
					ctl.fold = 1'b1;
					state_d  = bolb_pkg::ST_DONE;
				end
			end
			bolb_pkg::ST_DIV: begin
				if (sts.div_done) begin
					ctl.fold = 1'b1;
					state_d  = bolb_pkg::ST_DONE;
				end
			end
			bolb_pkg::ST_DONE: begin
				if (sts.last_box) begin
					ctl.finish = 1'b1;
					state_d    = bolb_pkg::ST_OUT;
				end else begin
					ctl.next = 1'b1;
					ctl.rd   = 1'b1;
					state_d  = bolb_pkg::ST_GEOM;
				end
			end
			bolb_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = bolb_pkg::ST_IDLE;
			end
			default: state_d = bolb_pkg::ST_IDLE;
		endcase
	end
endmodule

[src/bolb_dp.sv]
`timescale 1ns / 1ps
module bolb_dp #(
	parameter int MAX_BOXES  = 16,
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bolb_pkg::ctl_t        ctl,
	output bolb_pkg::sts_t        sts,
	input  logic [1:0]            command,
	input  logic [COORD_BITS-1:0] lo_left,
	input  logic [COORD_BITS-1:0] lo_top,
	input  logic [COORD_BITS-1:0] lo_right,
	input  logic [COORD_BITS-1:0] lo_bottom,
	input  logic [COORD_BITS-1:0] hi_left,
	input  logic [COORD_BITS-1:0] hi_top,
	input  logic [COORD_BITS-1:0] hi_right,
	input  logic [COORD_BITS-1:0] hi_bottom,
	input  logic                  negative_image,
	output logic [FRAC_BITS:0]    loss_value,
	output logic                  status
);
	localparam int CB  = COORD_BITS;
	localparam int SW  = CB + 2;           // signed edge span
	localparam int AW  = 2 * SW;           // signed area
	localparam int NSW = AW + 2;           // signed num/den
	localparam int DW  = NSW - 1;          // positive den
	localparam int QW  = DW + FRAC_BITS;
	localparam int IW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int KW  = $clog2(MAX_BOXES + 1);
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	logic [4*CB-1:0] mem [MAX_BOXES];
	logic [4*CB-1:0] ent_q;
	logic [KW-1:0]   count_q;
	logic            fneg_q;
	logic [IW-1:0]   idx_q;

	logic [1:0]      cmd_q;
	logic [CB-1:0]   ll_q, lt_q, lr_q, lb_q, hl_q, ht_q, hr_q, hb_q;

	logic signed [SW-1:0] gw_q, gh_q, mw_q, mh_q, xw_q, xh_q, iw_q, ih_q;
	logic                 zero_q;
	logic signed [AW-1:0] ga_q, ma_q, xa_q, ia_q;
	logic                 zero2_q;
	logic signed [NSW-1:0] num_q, den_q;
	logic                 ovz_q, ovone_q, needdiv_q;
	logic [FRAC_BITS:0]   best_q;
	logic [FRAC_BITS:0]   cand;
	logic                 div_done;
	logic [QW-1:0]        quo;

	// combinational geometry of registered entry
	logic signed [SW-1:0] el, et, er, eb, nl, nt, nr, nb, il, it, ir, ib;
	logic signed [NSW-1:0] num_c, den_c;

	always_comb begin
		el = SW'(ent_q[4*CB-1 -: CB]);
		et = SW'(ent_q[3*CB-1 -: CB]);
		er = SW'(ent_q[2*CB-1 -: CB]);
		eb = SW'(ent_q[CB-1:0]);
		nl = SW'(hl_q);
		nt = SW'(ht_q);
		nr = SW'(lr_q);
		nb = SW'(lb_q);
		il = (nl > el + SW'(1)) ? nl : el + SW'(1);
		it = (nt > et + SW'(1)) ? nt : et + SW'(1);
		ir = (nr < er + SW'(1)) ? nr : er + SW'(1);
		ib = (nb < eb + SW'(1)) ? nb : eb + SW'(1);
		num_c = NSW'(ma_q) + NSW'(ga_q);
		den_c = NSW'(ga_q) + NSW'(xa_q) - NSW'(ia_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fneg_q  <= 1'b0;
		end else if (ctl.take) begin
			if (command == bolb_pkg::CMD_CLEAR) begin
				count_q <= '0;
				fneg_q  <= 1'b0;
			end else if (command == bolb_pkg::CMD_LOAD && count_q < KW'(MAX_BOXES)) begin
				if (count_q == '0) fneg_q <= negative_image;
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take && command == bolb_pkg::CMD_LOAD && count_q < KW'(MAX_BOXES))
			mem[count_q[IW-1:0]] <= {lo_left, lo_top, lo_right, lo_bottom};
		if (ctl.rd)
			ent_q <= mem[ctl.next ? idx_q + 1'b1 : idx_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q <= command;
			ll_q <= lo_left;  lt_q <= lo_top;  lr_q <= lo_right;  lb_q <= lo_bottom;
			hl_q <= hi_left;  ht_q <= hi_top;  hr_q <= hi_right;  hb_q <= hi_bottom;
			// status reflects a dropped load
			status <= (command == bolb_pkg::CMD_LOAD) && (count_q >= KW'(MAX_BOXES));
			idx_q  <= '0;
			best_q <= '0;
		end
		if (ctl.next) idx_q <= idx_q + 1'b1;
		if (ctl.geom) begin
			gw_q <= er - el + SW'(1);  gh_q <= eb - et + SW'(1);
			mw_q <= nr - nl + SW'(1);  mh_q <= nb - nt + SW'(1);
			xw_q <= $signed(SW'(hr_q)) - $signed(SW'(ll_q)) + SW'(1);
			xh_q <= $signed(SW'(hb_q)) - $signed(SW'(lt_q)) + SW'(1);
			iw_q <= ir - il + SW'(1);  ih_q <= ib - it + SW'(1);
			zero_q <= (nr < nl) || (nb < nt) || (ir < il) || (ib < it);
		end
		if (ctl.area) begin
			ga_q <= AW'(gw_q) * AW'(gh_q);
			ma_q <= AW'(mw_q) * AW'(mh_q);
			xa_q <= AW'(xw_q) * AW'(xh_q);
			ia_q <= AW'(iw_q) * AW'(ih_q);
			zero2_q <= zero_q;
		end
		if (ctl.sums) begin
			num_q     <= num_c - den_c;
			den_q     <= den_c;
			ovz_q     <= zero2_q || den_c <= 0 || num_c <= den_c;
			ovone_q   <= num_c - den_c >= den_c;
			needdiv_q <= !(zero2_q || den_c <= 0 || num_c <= den_c)
			             && !(num_c - den_c >= den_c);
		end
		if (ctl.fold && cand > best_q) best_q <= cand;
		if (ctl.finish) begin
			if (cmd_q != bolb_pkg::CMD_QUERY || count_q == '0) loss_value <= '0;
			else if (fneg_q) loss_value <= ONE;
			else loss_value <= ONE - best_q;
		end
	end

	always_comb begin
		if (ovz_q)       cand = '0;
		else if (ovone_q) cand = ONE;
		else             cand = quo[FRAC_BITS:0];
	end

	bolb_div #(.NW(QW), .DW(DW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.div_start),
		.num   ({num_q[DW-1:0], FRAC_BITS'(0)}),
		.den   (den_q[DW-1:0]),
		.done  (div_done),
		.quo   (quo)
	);

	assign sts.is_query  = cmd_q == bolb_pkg::CMD_QUERY;
	assign sts.empty     = count_q == '0;
	assign sts.first_neg = fneg_q;
	assign sts.last_box  = KW'(idx_q) + 1'b1 >= count_q;
	assign sts.need_div  = needdiv_q;
	assign sts.div_done  = div_done;
endmodule

[src/box_overlap_loss_bound_unit.sv]
`timescale 1ns / 1ps
// Box overlap loss bound unit.
// Input channel (in): one request per command. Clear empties the table,
// load appends a ground-truth box (status=1 if the table is full), query
// returns 1 minus the best lower-bounded overlap, unsigned Q1.FRAC_BITS.
// Output channel (out): exactly one response per request, in order.
// Clear, load, unused commands and trivial queries (empty table or
// negative first box) pass from acceptance through READ to OUT, where
// out.valid is raised.
// A full query walks count stored boxes. Each box passes the GEOM, AREA,
// SUMS, NEXT and DONE states (geometry, area, sums and fold), and when the
// overlap is fractional also waits in DIV for the restoring divider
// (QW = 2*COORD_BITS+5+FRAC_BITS bits, 45 by default).
// One request is in flight at a time: in.ready is low from acceptance
// until the response is taken.
// Reset (arst_n low) empties the table and clears the negative flag;
// table contents are only read below the fill count.
// If out.ready is low the response holds on the port until taken.
module box_overlap_loss_bound_unit #(
	parameter int MAX_BOXES  = 16,
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input logic clk,
	input logic arst_n,
	bolb_in_if.sink    in,
	bolb_out_if.source out
);
	bolb_pkg::ctl_t ctl;
	bolb_pkg::sts_t sts;

	bolb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.out_valid(out.valid),
		.out_ready(out.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	bolb_dp #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.command       (in.command),
		.lo_left       (in.lo_left),
		.lo_top        (in.lo_top),
		.lo_right      (in.lo_right),
		.lo_bottom     (in.lo_bottom),
		.hi_left       (in.hi_left),
		.hi_top        (in.hi_top),
		.hi_right      (in.hi_right),
		.hi_bottom     (in.hi_bottom),
		.negative_image(in.negative_image),
		.loss_value    (out.loss_value),
		.status        (out.status)
	);
endmodule

[src/bolb_chk.sv]
`timescale 1ns / 1ps
module bolb_chk #(parameter int FRAC_BITS = 16) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [FRAC_BITS:0] loss_value,
	input logic               status
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while response pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(loss_value))
		else $error("response dropped");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> loss_value <= ((FRAC_BITS + 1)'(1) << FRAC_BITS))
		else $error("loss out of range");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> loss_value == '0) else $error("status with loss");
endmodule

bind box_overlap_loss_bound_unit bolb_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready),
	.loss_value(out.loss_value), .status(out.status));
